>>> sv/pdet_pkg.sv
// Shared types and constants of the power envelope pulse detector.
// No dependencies; imported by every module of the block.
package pdet_pkg;

  // Fixed geometry of the sample path
  localparam int SAMPLE_W   = 16;
  localparam int IDX_W      = 32;
  localparam int POW_W      = 32;
  localparam int SUM_W      = 41;
  localparam int PROD_W     = 42;
  localparam int WLEN_W     = 10;
  localparam int RING_DEPTH = 512;
  localparam int RING_AW    = 9;
  localparam int HIST_DEPTH = 513;
  localparam int HIST_AW    = 10;
  localparam int W_MIN      = 8;
  localparam int W_MAX      = 512;
  localparam int STEP_LIMIT = 1026;
  localparam int STEP_W     = 11;
  localparam int OUT_CAP    = 4;
  localparam int CNT_W      = 3;
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;
  localparam int FIFO_CW    = 4;

  // Configuration register indexes
  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_WINDOW    = 2'd1;
  localparam logic [1:0] REG_MIN_WIDTH = 2'd2;
  localparam logic [1:0] REG_MAX_WIDTH = 2'd3;

  // One result record
  typedef struct packed {
    logic [IDX_W-1:0] pulse_start;
    logic [IDX_W-1:0] pulse_end;
    logic             pulse_valid;
    logic             run_last;
  } result_t;

endpackage

>>> sv/pdet_res_fifo.sv
// Result queue of the pulse detector: a small register FIFO in front of the output port.
// Depends on pdet_pkg.
module pdet_res_fifo
  import pdet_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  result_t            push_data,
  input  logic               pop,
  output result_t            head,
  output logic               not_empty,
  output logic [FIFO_CW-1:0] count
);

  result_t              slot_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [FIFO_CW-1:0]   count_r;
  logic                 do_pop;

  assign not_empty = (count_r != '0);
  assign do_pop    = pop && not_empty;
  assign head      = slot_r[rd_ptr_r];
  assign count     = count_r;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_r + FIFO_CW'(push) - FIFO_CW'(do_pop);
    end
  end

endmodule

>>> sv/power_envelope_pulse_detector.sv
// Top level of the power envelope pulse detector: sequencer, power ring, history memory and result queue.
// Depends on pdet_pkg and pdet_res_fifo.
//
// Each accepted I/Q request stores its power in a 512-entry ring memory and then resolves
// every position whose envelope window is complete. A window sum is carried from position
// to position by one add and one subtract (two ring read ports). In steady state a sample
// goes from acceptance to the next ready through the sequencer steps accept, power write,
// ring-overwrite fixup, window check, sum update, threshold compare, the final readiness
// check and the close-out states FIN and DONE. Extra steps: the first window of a capture
// and the first window after a window_length write are summed one ring entry a cycle; a
// run start walks the above-history memory one entry a cycle to find the refined edge; an
// end_of_capture request resolves the whole tail with a window check, sum update and
// threshold compare per position, and adds the end marker. Results wait in an eight-entry
// queue; a new request is taken while that queue has room for four.
module power_envelope_pulse_detector
  import pdet_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_i,
  input  logic signed [SAMPLE_W-1:0] in_q,
  input  logic                       in_end_of_capture,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [IDX_W-1:0]           out_pulse_start,
  output logic [IDX_W-1:0]           out_pulse_end,
  output logic                       out_pulse_valid,
  output logic                       out_run_last,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [31:0]                cfg_wdata
);

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PWR  = 4'd1;
  localparam logic [3:0] S_ADJ  = 4'd2;
  localparam logic [3:0] S_CHK  = 4'd3;
  localparam logic [3:0] S_UPD  = 4'd4;
  localparam logic [3:0] S_SWP  = 4'd5;
  localparam logic [3:0] S_EVAL = 4'd6;
  localparam logic [3:0] S_SRCH = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;
  localparam logic [3:0] S_MRK  = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  // registers
  logic [3:0]                 state_r, state_nxt;
  logic signed [SAMPLE_W-1:0] i_r, i_nxt, q_r, q_nxt;
  logic                       last_r, last_nxt;
  logic [IDX_W-1:0]           n_r, n_nxt, p_r, p_nxt;
  logic [HIST_AW-1:0]         haddr_r, haddr_nxt;
  logic [7:0]                 phase_r, phase_nxt;
  logic                       in_run_r, in_run_nxt;
  logic [IDX_W-1:0]           coarse_r, coarse_nxt, refined_r, refined_nxt;
  logic [SUM_W-1:0]           sum_r, sum_nxt;
  logic [IDX_W-1:0]           sum_lo_r, sum_lo_nxt, sum_hi_r, sum_hi_nxt;
  logic                       sum_ok_r, sum_ok_nxt;
  logic [IDX_W-1:0]           tgt_lo_r, tgt_lo_nxt, tgt_hi_r, tgt_hi_nxt;
  logic                       dlo_r, dlo_nxt, dhi_r, dhi_nxt;
  logic [PROD_W-1:0]          prod_r, prod_nxt;
  logic [POW_W-1:0]           pow_r, pow_nxt;
  logic [STEP_W-1:0]          k_r, k_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [IDX_W-1:0]           swp_idx_r, swp_idx_nxt;
  logic                       swp_pend_r, swp_pend_nxt;
  logic [IDX_W-1:0]           s_idx_r, s_idx_nxt, s_chk_r, s_chk_nxt;
  logic [HIST_AW-1:0]         s_addr_r, s_addr_nxt;
  logic                       s_pend_r, s_pend_nxt;
  logic                       pend_v_r, pend_v_nxt;
  result_t                    pend_r, pend_nxt;
  logic [31:0]                thr_r, thr_nxt, minw_r, minw_nxt, maxw_r, maxw_nxt;
  logic [WLEN_W-1:0]          wl_r, wl_nxt;

  // memories
  logic [POW_W-1:0] ring_mem [RING_DEPTH];
  logic             hist_mem [HIST_DEPTH];
  logic [POW_W-1:0] rd_a, rd_b;
  logic             rd_h;
  logic             ring_we, hist_we, hist_wd;
  logic [RING_AW-1:0] ring_ra_a, ring_ra_b;
  logic [HIST_AW-1:0] hist_ra;

  // result path
  logic               push;
  result_t            push_data, head;
  logic               q_ne;
  logic [FIFO_CW-1:0] q_count;

  // combinational helpers
  logic [WLEN_W-1:0]  weff;
  logic [8:0]         half_w;
  logic [7:0]         stride;
  logic signed [31:0] sq_i, sq_q;
  logic [POW_W-1:0]   pow_c;
  logic [IDX_W-1:0]   lo_c, hi_c, j0_c, back_c;
  logic [IDX_W:0]     lo_w_c;
  logic               ready_c, incr_c;
  logic [WLEN_W-1:0]  wcnt_c, dist_c;
  logic [CNT_W-1:0]   cap_c;
  logic               above_c, scan_c;
  logic [7:0]         ph0_c, ph1_c;
  logic [IDX_W-1:0]   cw_c, rw_c, rwf_c;
  logic               close_ok_c, flush_ok_c;
  logic               emit_v;
  result_t            emit_d;

  // clamped window and its derived spans
  always_comb begin
    if (wl_r < WLEN_W'(W_MIN)) weff = WLEN_W'(W_MIN);
    else if (wl_r > WLEN_W'(W_MAX)) weff = WLEN_W'(W_MAX);
    else weff = wl_r;
  end
  assign half_w = weff[9:1];
  assign stride = weff[9:2];

  // sample power
  assign sq_i  = i_r * i_r;
  assign sq_q  = q_r * q_r;
  assign pow_c = POW_W'($unsigned(sq_i)) + POW_W'($unsigned(sq_q));

  // window of the position under test
  assign lo_c    = (p_r >= IDX_W'(half_w)) ? p_r - IDX_W'(half_w) : '0;
  assign lo_w_c  = {1'b0, lo_c} + (IDX_W+1)'(weff);
  assign hi_c    = (lo_w_c > {1'b0, n_r}) ? n_r : lo_w_c[IDX_W-1:0];
  assign ready_c = last_r ? (p_r < n_r) : (lo_w_c <= {1'b0, n_r});
  assign wcnt_c  = WLEN_W'(hi_c - lo_c);
  assign incr_c  = sum_ok_r && ((lo_c - sum_lo_r) <= IDX_W'(1)) &&
                   ((hi_c - sum_hi_r) <= IDX_W'(1));
  assign j0_c    = n_r - IDX_W'(RING_DEPTH + 1);

  // threshold compare and scan grid
  assign above_c = {1'b0, sum_r} > prod_r;
  assign ph0_c   = (phase_r >= stride) ? 8'd0 : phase_r;
  assign scan_c  = (ph0_c == 8'd0);
  assign ph1_c   = ph0_c + 8'd1;

  // run-start back limit in the history
  assign back_c  = (p_r >= IDX_W'(weff)) ? p_r - IDX_W'(weff) : '0;
  assign dist_c  = WLEN_W'(p_r - back_c);

  // width filters
  assign cw_c       = p_r - coarse_r;
  assign rw_c       = p_r - refined_r;
  assign rwf_c      = n_r - refined_r;
  assign close_ok_c = (cw_c >= {1'b0, minw_r[31:1]}) && ({1'b0, cw_c} <= {maxw_r, 1'b0}) &&
                      (rw_c >= minw_r) && (rw_c <= maxw_r);
  assign flush_ok_c = (rwf_c >= minw_r) && (rwf_c <= maxw_r);
  assign cap_c      = last_r ? CNT_W'(OUT_CAP - 1) : CNT_W'(OUT_CAP);

  // power ring: read before write on port A
  always_ff @(posedge clk) begin
    if (ring_we) ring_mem[n_r[RING_AW-1:0]] <= pow_c;
    rd_a <= ring_mem[ring_ra_a];
    rd_b <= ring_mem[ring_ra_b];
  end

  // above history
  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[haddr_r] <= hist_wd;
    rd_h <= hist_mem[hist_ra];
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    i_nxt        = i_r;
    q_nxt        = q_r;
    last_nxt     = last_r;
    n_nxt        = n_r;
    p_nxt        = p_r;
    haddr_nxt    = haddr_r;
    phase_nxt    = phase_r;
    in_run_nxt   = in_run_r;
    coarse_nxt   = coarse_r;
    refined_nxt  = refined_r;
    sum_nxt      = sum_r;
    sum_lo_nxt   = sum_lo_r;
    sum_hi_nxt   = sum_hi_r;
    sum_ok_nxt   = sum_ok_r;
    tgt_lo_nxt   = tgt_lo_r;
    tgt_hi_nxt   = tgt_hi_r;
    dlo_nxt      = dlo_r;
    dhi_nxt      = dhi_r;
    prod_nxt     = prod_r;
    pow_nxt      = pow_r;
    k_nxt        = k_r;
    cnt_nxt      = cnt_r;
    swp_idx_nxt  = swp_idx_r;
    swp_pend_nxt = swp_pend_r;
    s_idx_nxt    = s_idx_r;
    s_chk_nxt    = s_chk_r;
    s_addr_nxt   = s_addr_r;
    s_pend_nxt   = s_pend_r;
    pend_v_nxt   = pend_v_r;
    pend_nxt     = pend_r;
    thr_nxt      = thr_r;
    wl_nxt       = wl_r;
    minw_nxt     = minw_r;
    maxw_nxt     = maxw_r;
    ring_we      = 1'b0;
    ring_ra_a    = sum_lo_r[RING_AW-1:0];
    ring_ra_b    = sum_hi_r[RING_AW-1:0];
    hist_we      = 1'b0;
    hist_wd      = above_c;
    hist_ra      = s_addr_r;
    emit_v       = 1'b0;
    emit_d       = '0;
    push         = 1'b0;
    push_data    = pend_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          i_nxt     = in_i;
          q_nxt     = in_q;
          last_nxt  = in_end_of_capture;
          state_nxt = S_PWR;
        end
      end
      // write the new power, fetch what it overwrites
      S_PWR: begin
        ring_we   = 1'b1;
        ring_ra_a = n_r[RING_AW-1:0];
        pow_nxt   = pow_c;
        n_nxt     = n_r + 1'b1;
        k_nxt     = '0;
        cnt_nxt   = '0;
        state_nxt = S_ADJ;
      end
      // keep the carried sum equal to the ring contents of its window
      S_ADJ: begin
        if (sum_ok_r && (n_r > IDX_W'(RING_DEPTH)) && (sum_lo_r <= j0_c) && (j0_c < sum_hi_r))
          sum_nxt = sum_r + SUM_W'(pow_r) - SUM_W'(rd_a);
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (!ready_c || (k_r == STEP_W'(STEP_LIMIT))) begin
          state_nxt = S_FIN;
        end else begin
          tgt_lo_nxt = lo_c;
          tgt_hi_nxt = hi_c;
          prod_nxt   = thr_r * wcnt_c;
          if (incr_c) begin
            dlo_nxt   = (lo_c != sum_lo_r);
            dhi_nxt   = (hi_c != sum_hi_r);
            state_nxt = S_UPD;
          end else begin
            sum_nxt      = '0;
            swp_idx_nxt  = lo_c;
            swp_pend_nxt = 1'b0;
            state_nxt    = S_SWP;
          end
        end
      end
      // slide the window by up to one entry at each end
      S_UPD: begin
        sum_nxt    = sum_r + (dhi_r ? SUM_W'(rd_b) : '0) - (dlo_r ? SUM_W'(rd_a) : '0);
        sum_lo_nxt = tgt_lo_r;
        sum_hi_nxt = tgt_hi_r;
        sum_ok_nxt = 1'b1;
        state_nxt  = S_EVAL;
      end
      // full window sum, one ring entry a cycle
      S_SWP: begin
        ring_ra_a = swp_idx_r[RING_AW-1:0];
        if (swp_pend_r) sum_nxt = sum_r + SUM_W'(rd_a);
        if (swp_idx_r != tgt_hi_r) begin
          swp_idx_nxt  = swp_idx_r + 1'b1;
          swp_pend_nxt = 1'b1;
        end else begin
          swp_pend_nxt = 1'b0;
          if (!swp_pend_r) begin
            sum_lo_nxt = tgt_lo_r;
            sum_hi_nxt = tgt_hi_r;
            sum_ok_nxt = 1'b1;
            state_nxt  = S_EVAL;
          end
        end
      end
      // threshold, history, run open and close
      S_EVAL: begin
        hist_we   = 1'b1;
        phase_nxt = (ph1_c >= stride) ? 8'd0 : ph1_c;
        p_nxt     = p_r + 1'b1;
        haddr_nxt = (haddr_r == HIST_AW'(HIST_DEPTH - 1)) ? '0 : haddr_r + 1'b1;
        k_nxt     = k_r + 1'b1;
        state_nxt = S_CHK;
        if (scan_c && above_c && !in_run_r) begin
          in_run_nxt = 1'b1;
          coarse_nxt = p_r;
          s_idx_nxt  = back_c;
          s_pend_nxt = 1'b0;
          s_addr_nxt = (haddr_r >= dist_c) ? haddr_r - dist_c :
                       haddr_r + HIST_AW'(HIST_DEPTH) - dist_c;
          state_nxt  = S_SRCH;
        end else if (scan_c && !above_c && in_run_r) begin
          in_run_nxt = 1'b0;
          if (close_ok_c) begin
            emit_v = 1'b1;
            emit_d = '{pulse_start: refined_r, pulse_end: p_r, pulse_valid: 1'b1,
                       run_last: 1'b0};
          end
        end
      end
      // earliest above position at or after the back limit
      S_SRCH: begin
        if (s_pend_r && rd_h) begin
          refined_nxt = s_chk_r;
          state_nxt   = S_CHK;
        end else begin
          s_chk_nxt  = s_idx_r;
          s_idx_nxt  = s_idx_r + 1'b1;
          s_addr_nxt = (s_addr_r == HIST_AW'(HIST_DEPTH - 1)) ? '0 : s_addr_r + 1'b1;
          s_pend_nxt = 1'b1;
        end
      end
      // open run at end of capture
      S_FIN: begin
        if (last_r && in_run_r && flush_ok_c) begin
          emit_v = 1'b1;
          emit_d = '{pulse_start: refined_r, pulse_end: n_r, pulse_valid: 1'b1,
                     run_last: 1'b0};
        end
        state_nxt = last_r ? S_MRK : S_DONE;
      end
      // end marker, then a fresh capture
      S_MRK: begin
        emit_v      = 1'b1;
        emit_d      = '{pulse_start: '0, pulse_end: n_r, pulse_valid: 1'b0, run_last: 1'b0};
        n_nxt       = '0;
        p_nxt       = '0;
        haddr_nxt   = '0;
        phase_nxt   = '0;
        in_run_nxt  = 1'b0;
        coarse_nxt  = '0;
        refined_nxt = '0;
        sum_ok_nxt  = 1'b0;
        state_nxt   = S_DONE;
      end
      // last result of the request gets its flag
      S_DONE: begin
        if (pend_v_r) begin
          push      = 1'b1;
          push_data = pend_r;
          push_data.run_last = 1'b1;
          pend_v_nxt = 1'b0;
        end
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    // one result held back so the final one can be flagged
    if (emit_v && ((cnt_r < cap_c) || (state_r == S_MRK))) begin
      if (pend_v_r) begin
        push      = 1'b1;
        push_data = pend_r;
      end
      pend_nxt   = emit_d;
      pend_v_nxt = 1'b1;
      cnt_nxt    = cnt_r + 1'b1;
    end

    // configuration writes
    if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD: thr_nxt  = cfg_wdata;
        REG_WINDOW: begin
          wl_nxt     = cfg_wdata[WLEN_W-1:0];
          sum_ok_nxt = 1'b0;
        end
        REG_MIN_WIDTH: minw_nxt = cfg_wdata;
        REG_MAX_WIDTH: maxw_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      n_r       <= '0;
      p_r       <= '0;
      haddr_r   <= '0;
      phase_r   <= '0;
      in_run_r  <= 1'b0;
      coarse_r  <= '0;
      refined_r <= '0;
      sum_ok_r  <= 1'b0;
      k_r       <= '0;
      cnt_r     <= '0;
      pend_v_r  <= 1'b0;
      thr_r     <= '0;
      wl_r      <= WLEN_W'(64);
      minw_r    <= 32'd1;
      maxw_r    <= 32'hFFFF_FFFF;
    end else begin
      state_r   <= state_nxt;
      n_r       <= n_nxt;
      p_r       <= p_nxt;
      haddr_r   <= haddr_nxt;
      phase_r   <= phase_nxt;
      in_run_r  <= in_run_nxt;
      coarse_r  <= coarse_nxt;
      refined_r <= refined_nxt;
      sum_ok_r  <= sum_ok_nxt;
      k_r       <= k_nxt;
      cnt_r     <= cnt_nxt;
      pend_v_r  <= pend_v_nxt;
      thr_r     <= thr_nxt;
      wl_r      <= wl_nxt;
      minw_r    <= minw_nxt;
      maxw_r    <= maxw_nxt;
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    q_r        <= q_nxt;
    last_r     <= last_nxt;
    sum_r      <= sum_nxt;
    sum_lo_r   <= sum_lo_nxt;
    sum_hi_r   <= sum_hi_nxt;
    tgt_lo_r   <= tgt_lo_nxt;
    tgt_hi_r   <= tgt_hi_nxt;
    dlo_r      <= dlo_nxt;
    dhi_r      <= dhi_nxt;
    prod_r     <= prod_nxt;
    pow_r      <= pow_nxt;
    swp_idx_r  <= swp_idx_nxt;
    swp_pend_r <= swp_pend_nxt;
    s_idx_r    <= s_idx_nxt;
    s_chk_r    <= s_chk_nxt;
    s_addr_r   <= s_addr_nxt;
    s_pend_r   <= s_pend_nxt;
    pend_r     <= pend_nxt;
  end

  // result queue
  pdet_res_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (out_ready),
    .head      (head),
    .not_empty (q_ne),
    .count     (q_count)
  );

  assign in_ready        = (state_r == S_IDLE) && (q_count <= FIFO_CW'(FIFO_DEPTH - OUT_CAP));
  assign out_valid       = q_ne;
  assign out_pulse_start = head.pulse_start;
  assign out_pulse_end   = head.pulse_end;
  assign out_pulse_valid = head.pulse_valid;
  assign out_run_last    = head.run_last;

endmodule

>>> sv/pdet_checker.sv
// Port-level checks of the pulse detector, bound to the top level.
// Depends on pdet_pkg and power_envelope_pulse_detector.
module pdet_checker
  import pdet_pkg::*;
(
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [IDX_W-1:0]           out_pulse_start,
  input logic                       out_pulse_valid,
  input logic                       out_run_last
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // the end marker closes its request and carries no start
  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_pulse_valid |-> out_run_last && (out_pulse_start == '0))
    else $error("malformed end marker");

  // one request at a time: no acceptance in the cycle after one
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

endmodule

bind power_envelope_pulse_detector pdet_checker u_pdet_checker (.*);
